// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("assertion failed");

`endif

// ----- hw/rtl/lkt_pkg.sv -----
`default_nettype none

package lkt_pkg;

	localparam int REQ_W     = 2;
	localparam int STAT_W    = 2;
	localparam int CAP_W     = 5;
	localparam int OCC_W     = 5;
	localparam int PORT_KEY_W = 64;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// request codes
	localparam logic [REQ_W-1:0] REQ_TOUCH  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_EVICT  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

	// rank update applied by the compare unit during the update pass
	typedef enum logic [1:0] {
		OP_HIT = 2'd0,
		OP_INS = 2'd1,
		OP_DEL = 2'd2
	} lkt_op_t;

	typedef struct packed {
		logic key_eq;
		logic rank_eq;
	} lkt_cmp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lkt_store.sv -----
`default_nettype none

module lkt_store #(
	parameter int ENTRIES  = 16,
	parameter int KEY_BITS = 64
) (
	input  wire logic                        clk,
	input  wire logic                        rd_en,
	input  wire logic [$clog2(ENTRIES)-1:0]  rd_addr,
	output logic      [KEY_BITS-1:0]         rd_key,
	output logic      [$clog2(ENTRIES)-1:0]  rd_rank,
	input  wire logic                        wr_en,
	input  wire logic [$clog2(ENTRIES)-1:0]  wr_addr,
	input  wire logic [KEY_BITS-1:0]         wr_key,
	input  wire logic [$clog2(ENTRIES)-1:0]  wr_rank
);

	localparam int RANK_W = $clog2(ENTRIES);
	localparam int WORD_W = RANK_W + KEY_BITS;

	// word = {rank, key}
	logic [WORD_W-1:0] mem_q [ENTRIES];
	logic [WORD_W-1:0] rd_word_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= {wr_rank, wr_key};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_word_q <= mem_q[rd_addr];
		end
	end

	assign rd_key  = rd_word_q[KEY_BITS-1:0];
	assign rd_rank = rd_word_q[WORD_W-1:KEY_BITS];

endmodule

`default_nettype wire

// ----- hw/rtl/lkt_cmp.sv -----
`default_nettype none

module lkt_cmp #(
	parameter int KEY_BITS = 64,
	parameter int RANK_W   = 4
) (
	input  wire lkt_pkg::lkt_op_t    mode,
	input  wire logic [KEY_BITS-1:0] entry_key,
	input  wire logic [KEY_BITS-1:0] probe_key,
	input  wire logic [RANK_W-1:0]   entry_rank,
	input  wire logic [RANK_W-1:0]   ref_rank,
	output lkt_pkg::lkt_cmp_t        flags,
	output logic      [RANK_W-1:0]   new_rank
);

	logic rank_lt;
	logic rank_gt;

	assign rank_lt = entry_rank < ref_rank;
	assign rank_gt = entry_rank > ref_rank;

	assign flags.key_eq  = entry_key == probe_key;
	assign flags.rank_eq = entry_rank == ref_rank;

	always_comb begin
		new_rank = entry_rank;
		case (mode)
			lkt_pkg::OP_HIT: begin
				if (rank_lt) new_rank = entry_rank + 1'b1;
			end
			lkt_pkg::OP_INS: begin
				new_rank = entry_rank + 1'b1;
			end
			lkt_pkg::OP_DEL: begin
				if (rank_gt) new_rank = entry_rank - 1'b1;
			end
			default: begin
				new_rank = entry_rank;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/lru_key_tracker.sv -----
// lru_key_tracker: LRU list of up to ENTRIES keys, one request at a time.
// An unused request or evict on empty finishes at acceptance with done registered;
// evict, touch miss on full and delete of an absent key run the scan and decide
// steps; touch hit, insert and delete of a present key add the update pass.
// busy drops in the done cycle, so a new request is accepted only from then on; done is a
// one-cycle strobe, receiver cannot stall. arst_n frees all entries, capacity 16.
`default_nettype none
`include "assert_macros.svh"

module lru_key_tracker #(
	parameter int ENTRIES  = 16,
	parameter int KEY_BITS = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration
	input  wire logic                                cfg_we,
	input  wire logic [lkt_pkg::CAP_W-1:0]           cfg_wdata,
	// request
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [lkt_pkg::REQ_W-1:0]           req_type,
	input  wire logic [lkt_pkg::PORT_KEY_W-1:0]      key,
	// result
	output logic                                     done,
	output logic      [lkt_pkg::STAT_W-1:0]          status,
	output logic                                     hit,
	output logic      [lkt_pkg::PORT_KEY_W-1:0]      evicted_key,
	output logic      [lkt_pkg::OCC_W-1:0]           occupancy
);

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int RANK_W = IDX_W;
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int CW     = (CNT_W > lkt_pkg::CAP_W) ? CNT_W : lkt_pkg::CAP_W;

	localparam logic [IDX_W:0]   ISS_END  = (IDX_W+1)'(ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
	localparam logic [CW-1:0]    ENT_CW   = CW'(ENTRIES);

	// Sequencer: scan pass reads every entry through the compare unit,
	// decision cycle picks the outcome, update pass rewrites ranks.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_DEC  = 4'b0100,
		ST_UPD  = 4'b1000
	} state_t;

	state_t state_q;

	logic [lkt_pkg::CAP_W-1:0] cap_q;
	logic [ENTRIES-1:0]        valid_q;
	logic [CNT_W-1:0]          count_q;

	// latched request
	logic [lkt_pkg::REQ_W-1:0] req_q;
	logic [KEY_BITS-1:0]       key_q;
	lkt_pkg::lkt_op_t          op_q;

	// memory issue counter and read-data stage
	logic [IDX_W:0]            iss_q;
	logic                      chk_v_s1;
	logic [IDX_W-1:0]          chk_idx_s1;

	// scan findings
	logic                      match_q;
	logic [IDX_W-1:0]          m_idx_q;
	logic [RANK_W-1:0]         m_rank_q;
	logic                      free_q;
	logic [IDX_W-1:0]          f_idx_q;
	logic                      evf_q;
	logic [IDX_W-1:0]          ev_idx_q;
	logic [KEY_BITS-1:0]       ev_key_q;

	// result registers
	logic                          done_q;
	logic [lkt_pkg::STAT_W-1:0]    status_q;
	logic                          hit_q;
	logic [lkt_pkg::PORT_KEY_W-1:0] ev_out_q;
	logic [lkt_pkg::OCC_W-1:0]     occ_q;

	// memory and compare unit wiring
	logic                  rd_en;
	logic [IDX_W-1:0]      rd_addr;
	logic [KEY_BITS-1:0]   rd_key;
	logic [RANK_W-1:0]     rd_rank;
	logic                  wr_en;
	logic [KEY_BITS-1:0]   wr_key;
	logic [RANK_W-1:0]     wr_rank;
	logic [RANK_W-1:0]     ref_rank;
	lkt_pkg::lkt_cmp_t     cmp_flags;
	logic [RANK_W-1:0]     new_rank;

	logic                  vld_s1;
	logic                  last_s1;
	logic                  ins_slot_s1;
	logic                  hit_slot_s1;
	logic [CW-1:0]         eff_cap;
	logic                  full;
	logic                  accept;

	assign busy   = state_q != ST_IDLE;
	assign accept = start && !busy;

	assign rd_en   = ((state_q == ST_SCAN) || (state_q == ST_UPD)) && (iss_q < ISS_END);
	assign rd_addr = iss_q[IDX_W-1:0];

	assign vld_s1      = valid_q[chk_idx_s1];
	assign last_s1     = chk_v_s1 && (chk_idx_s1 == LAST_IDX);
	assign ins_slot_s1 = (op_q == lkt_pkg::OP_INS) && (chk_idx_s1 == f_idx_q);
	assign hit_slot_s1 = (op_q == lkt_pkg::OP_HIT) && (chk_idx_s1 == m_idx_q);

	// Scan compares ranks against the least recent one (evict);
	// update compares against the rank of the touched or deleted key.
	assign ref_rank = (state_q == ST_SCAN) ? RANK_W'(count_q - 1'b1) : m_rank_q;

	// Rank write-back: valid entries get their new rank, the hit entry and
	// the freshly inserted entry become most recent.
	assign wr_en = (state_q == ST_UPD) && chk_v_s1 && (vld_s1 || ins_slot_s1);
	always_comb begin
		wr_key  = rd_key;
		wr_rank = new_rank;
		if (ins_slot_s1) begin
			wr_key  = key_q;
			wr_rank = '0;
		end else if (hit_slot_s1) begin
			wr_rank = '0;
		end
	end

	// effective capacity: 0 acts as 1, anything above ENTRIES as ENTRIES
	always_comb begin
		eff_cap = CW'(cap_q);
		if (cap_q == '0) eff_cap = CW'(1);
		if (CW'(cap_q) > ENT_CW) eff_cap = ENT_CW;
	end
	assign full = CW'(count_q) >= eff_cap;

	lkt_store #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_BITS)
	) u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_key  (rd_key),
		.rd_rank (rd_rank),
		.wr_en   (wr_en),
		.wr_addr (chk_idx_s1),
		.wr_key  (wr_key),
		.wr_rank (wr_rank)
	);

	lkt_cmp #(
		.KEY_BITS (KEY_BITS),
		.RANK_W   (RANK_W)
	) u_cmp (
		.mode       (op_q),
		.entry_key  (rd_key),
		.probe_key  (key_q),
		.entry_rank (rd_rank),
		.ref_rank   (ref_rank),
		.flags      (cmp_flags),
		.new_rank   (new_rank)
	);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkt_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// memory read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_v_s1 <= 1'b0;
		end else begin
			chk_v_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) chk_idx_s1 <= rd_addr;
	end

	// sequencer and list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			valid_q  <= '0;
			count_q  <= '0;
			iss_q    <= '0;
			match_q  <= 1'b0;
			free_q   <= 1'b0;
			evf_q    <= 1'b0;
			done_q   <= 1'b0;
			op_q     <= lkt_pkg::OP_HIT;
		end else begin
			done_q <= 1'b0;
			if (rd_en) iss_q <= iss_q + 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						iss_q   <= '0;
						match_q <= 1'b0;
						free_q  <= 1'b0;
						evf_q   <= 1'b0;
						if (!(req_type inside {lkt_pkg::REQ_TOUCH, lkt_pkg::REQ_EVICT,
						                       lkt_pkg::REQ_DELETE})) begin
							// unused code: no change
							done_q <= 1'b1;
						end else if ((req_type == lkt_pkg::REQ_EVICT) && (count_q == '0)) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (chk_v_s1) begin
						if (vld_s1 && cmp_flags.key_eq && !match_q) begin
							match_q <= 1'b1;
						end
						if (!vld_s1 && !free_q) begin
							free_q <= 1'b1;
						end
						if (vld_s1 && cmp_flags.rank_eq && !evf_q) begin
							evf_q <= 1'b1;
						end
						if (last_s1) state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					iss_q <= '0;
					case (req_q)
						lkt_pkg::REQ_TOUCH: begin
							if (match_q) begin
								op_q    <= lkt_pkg::OP_HIT;
								state_q <= ST_UPD;
							end else if (full || !free_q) begin
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end else begin
								op_q    <= lkt_pkg::OP_INS;
								state_q <= ST_UPD;
							end
						end
						lkt_pkg::REQ_EVICT: begin
							valid_q[ev_idx_q] <= 1'b0;
							count_q <= count_q - 1'b1;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
						lkt_pkg::REQ_DELETE: begin
							if (match_q) begin
								valid_q[m_idx_q] <= 1'b0;
								count_q <= count_q - 1'b1;
								op_q    <= lkt_pkg::OP_DEL;
								state_q <= ST_UPD;
							end else begin
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_UPD: begin
					if (last_s1) begin
						if (op_q == lkt_pkg::OP_INS) begin
							valid_q[f_idx_q] <= 1'b1;
							count_q <= count_q + 1'b1;
						end
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload: request latch, scan captures, result fields
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					req_q    <= req_type;
					key_q    <= key[KEY_BITS-1:0];
					status_q <= lkt_pkg::STAT_OK;
					hit_q    <= 1'b0;
					ev_out_q <= '0;
					occ_q    <= lkt_pkg::OCC_W'(count_q);
					if ((req_type == lkt_pkg::REQ_EVICT) && (count_q == '0)) begin
						status_q <= lkt_pkg::STAT_EMPTY;
					end
				end
			end
			ST_SCAN: begin
				if (chk_v_s1) begin
					if (vld_s1 && cmp_flags.key_eq && !match_q) begin
						m_idx_q  <= chk_idx_s1;
						m_rank_q <= rd_rank;
					end
					if (!vld_s1 && !free_q) f_idx_q <= chk_idx_s1;
					if (vld_s1 && cmp_flags.rank_eq && !evf_q) begin
						ev_idx_q <= chk_idx_s1;
						ev_key_q <= rd_key;
					end
				end
			end
			ST_DEC: begin
				case (req_q)
					lkt_pkg::REQ_TOUCH: begin
						if (!match_q && (full || !free_q)) status_q <= lkt_pkg::STAT_FULL;
					end
					lkt_pkg::REQ_EVICT: begin
						ev_out_q <= lkt_pkg::PORT_KEY_W'(ev_key_q);
						occ_q    <= lkt_pkg::OCC_W'(count_q - 1'b1);
					end
					lkt_pkg::REQ_DELETE: begin
						if (match_q) begin
							occ_q <= lkt_pkg::OCC_W'(count_q - 1'b1);
						end else begin
							status_q <= lkt_pkg::STAT_ABSENT;
						end
					end
					default: begin
						status_q <= lkt_pkg::STAT_OK;
					end
				endcase
			end
			ST_UPD: begin
				if (last_s1) begin
					hit_q <= op_q == lkt_pkg::OP_HIT;
					if (op_q == lkt_pkg::OP_INS) begin
						occ_q <= lkt_pkg::OCC_W'(count_q + 1'b1);
					end
				end
			end
			default: begin
				hit_q <= 1'b0;
			end
		endcase
	end

	assign done        = done_q;
	assign status      = status_q;
	assign hit         = hit_q;
	assign evicted_key = ev_out_q;
	assign occupancy   = occ_q;

	// the occupancy count follows the valid bits
	`ASSERT_CLK_RST(a_count_matches_valid, clk, arst_n, ($countones(valid_q) == int'(count_q)))
	// the list memory is written only during the rank update pass
	`ASSERT_CLK_RST(a_write_in_update, clk, arst_n, (wr_en |-> (state_q == ST_UPD)))
	// an accepted request either starts a pass or finishes at once
	`ASSERT_CLK_RST(a_accept_progress, clk, arst_n, (accept |=> (busy || done)))
	// evict on a non-empty list always finds the least recent entry
	`ASSERT_CLK_RST(a_evict_found, clk, arst_n,
		(((state_q == ST_DEC) && (req_q == lkt_pkg::REQ_EVICT)) |-> evf_q))

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lkt_pkg::*;

	localparam int LKT_ENTRIES = 16;
	localparam int LKT_KEY_W   = 64;
	// hard stop for the run
	localparam int CYCLE_LIMIT = 400000;
	// the longest request runs scan, decide and update pass; drain past its end
	localparam int DRAIN_CYCLES = 2 * LKT_ENTRIES + 8;

	// request type 3 has no meaning; the block answers it with the current count
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	localparam logic [63:0] K_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] K_A5   = 64'hA5A5_A5A5_A5A5_A5A5;
	localparam logic [63:0] K_5A   = 64'h5A5A_5A5A_5A5A_5A5A;

	// one result transfer, field by field
	typedef struct packed {
		logic [STAT_W-1:0]     status;
		logic                  hit;
		logic [PORT_KEY_W-1:0] evicted;
		logic [OCC_W-1:0]      occupancy;
	} lru_result_t;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	// Directed row. For ROW_CFG the key column carries the capacity value.
	// Rows with chk set use the typed-in result; the rest use the predictor.
	typedef struct packed {
		row_kind_t             kind;
		logic [REQ_W-1:0]      rq;
		logic [PORT_KEY_W-1:0] k;
		logic                  chk;
		logic [STAT_W-1:0]     st;
		logic                  ht;
		logic [PORT_KEY_W-1:0] ev;
		logic [OCC_W-1:0]      occ;
	} step_row_t;

	localparam int N_ROWS = 27;

	step_row_t dir_rows [N_ROWS] = '{
		// empty table: evict and delete both fail
		'{ROW_REQ, REQ_EVICT,  64'd0,  1'b1, STAT_EMPTY,  1'b0, 64'd0,  5'd0},
		'{ROW_REQ, REQ_DELETE, 64'd0,  1'b1, STAT_ABSENT, 1'b0, 64'd0,  5'd0},
		// all-zero and all-one keys, then a hit
		'{ROW_REQ, REQ_TOUCH,  64'd0,  1'b1, STAT_OK,     1'b0, 64'd0,  5'd1},
		'{ROW_REQ, REQ_TOUCH,  K_ONES, 1'b1, STAT_OK,     1'b0, 64'd0,  5'd2},
		'{ROW_REQ, REQ_TOUCH,  64'd0,  1'b1, STAT_OK,     1'b1, 64'd0,  5'd2},
		// unused type: no change
		'{ROW_REQ, REQ_UNUSED, K_ONES, 1'b1, STAT_OK,     1'b0, 64'd0,  5'd2},
		'{ROW_REQ, REQ_TOUCH,  K_A5,   1'b0, STAT_OK,     1'b0, 64'd0,  5'd0},
		// order is A5, 0, ones: ones is least recent
		'{ROW_REQ, REQ_EVICT,  64'd0,  1'b1, STAT_OK,     1'b0, K_ONES, 5'd2},
		'{ROW_REQ, REQ_DELETE, 64'd0,  1'b1, STAT_OK,     1'b0, 64'd0,  5'd1},
		'{ROW_REQ, REQ_DELETE, 64'd0,  1'b1, STAT_ABSENT, 1'b0, 64'd0,  5'd1},
		'{ROW_REQ, REQ_TOUCH,  K_5A,   1'b0, STAT_OK,     1'b0, 64'd0,  5'd0},
		'{ROW_REQ, REQ_EVICT,  K_ONES, 1'b1, STAT_OK,     1'b0, K_A5,   5'd1},
		'{ROW_REQ, REQ_EVICT,  64'd0,  1'b1, STAT_OK,     1'b0, K_5A,   5'd0},
		'{ROW_REQ, REQ_EVICT,  64'd0,  1'b1, STAT_EMPTY,  1'b0, 64'd0,  5'd0},
		// capacity 2: insert on full fails, hit on full still works
		'{ROW_CFG, REQ_TOUCH,  64'd2,  1'b0, STAT_OK,     1'b0, 64'd0,  5'd0},
		'{ROW_REQ, REQ_TOUCH,  64'd1,  1'b1, STAT_OK,     1'b0, 64'd0,  5'd1},
		'{ROW_REQ, REQ_TOUCH,  64'd2,  1'b1, STAT_OK,     1'b0, 64'd0,  5'd2},
		'{ROW_REQ, REQ_TOUCH,  64'd3,  1'b1, STAT_FULL,   1'b0, 64'd0,  5'd2},
		'{ROW_REQ, REQ_TOUCH,  64'd1,  1'b1, STAT_OK,     1'b1, 64'd0,  5'd2},
		// capacity 0 acts as 1, now below the count: entries stay
		'{ROW_CFG, REQ_TOUCH,  64'd0,  1'b0, STAT_OK,     1'b0, 64'd0,  5'd0},
		'{ROW_REQ, REQ_TOUCH,  64'd4,  1'b1, STAT_FULL,   1'b0, 64'd0,  5'd2},
		'{ROW_REQ, REQ_EVICT,  64'd0,  1'b1, STAT_OK,     1'b0, 64'd2,  5'd1},
		'{ROW_REQ, REQ_TOUCH,  64'd4,  1'b1, STAT_FULL,   1'b0, 64'd0,  5'd1},
		// capacity 31 clamps to the entry count
		'{ROW_CFG, REQ_TOUCH,  64'd31, 1'b0, STAT_OK,     1'b0, 64'd0,  5'd0},
		'{ROW_REQ, REQ_TOUCH,  64'd4,  1'b0, STAT_OK,     1'b0, 64'd0,  5'd0},
		'{ROW_REQ, REQ_EVICT,  64'd0,  1'b1, STAT_OK,     1'b0, 64'd1,  5'd1},
		'{ROW_REQ, REQ_DELETE, 64'd4,  1'b1, STAT_OK,     1'b0, 64'd0,  5'd0}
	};

	// random phases: capacity, sender idle percent, counted requests
	localparam int N_PHASES = 7;
	localparam logic [CAP_W-1:0] PH_CAP  [N_PHASES] = '{5'd16, 5'd4, 5'd1, 5'd31, 5'd0,
		5'd9, 5'd16};
	localparam int               PH_IDLE [N_PHASES] = '{0, 70, 0, 34, 70, 0, 34};
	localparam int               PH_REQS [N_PHASES] = '{120, 90, 60, 100, 50, 90, 90};

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CAP_W-1:0]      cfg_wdata = '0;
	logic                  start     = 1'b0;
	logic                  busy;
	logic [REQ_W-1:0]      req_type  = '0;
	logic [PORT_KEY_W-1:0] key       = '0;
	logic                  done;
	logic [STAT_W-1:0]     status;
	logic                  hit;
	logic [PORT_KEY_W-1:0] evicted_key;
	logic [OCC_W-1:0]      occupancy;

	lru_key_tracker #(
		.ENTRIES (LKT_ENTRIES),
		.KEY_BITS(LKT_KEY_W)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.key        (key),
		.done       (done),
		.status     (status),
		.hit        (hit),
		.evicted_key(evicted_key),
		.occupancy  (occupancy)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Shadow LRU list: same state as the block, updated per accepted
	// request in acceptance order.
	// ---------------------------------------------------------------
	logic [PORT_KEY_W-1:0] shadow_key   [LKT_ENTRIES];
	logic                  shadow_valid [LKT_ENTRIES];
	logic [3:0]            shadow_rank  [LKT_ENTRIES];
	logic [OCC_W-1:0]      held_count;
	logic [CAP_W-1:0]      cap_reg;

	lru_result_t pending_results [$];   // results owed by the block, oldest first
	lru_result_t mon_exp;
	int          errors   = 0;
	int          cycles   = 0;
	int          n_reqs   = 0;
	int          n_hits   = 0;
	int          n_full   = 0;
	int          n_absent = 0;
	int          n_empty  = 0;
	int          n_evicts = 0;
	int          idle_pct = 0;

	function automatic int shadow_find(logic [PORT_KEY_W-1:0] k);
		for (int i = 0; i < LKT_ENTRIES; i++)
			if (shadow_valid[i] && shadow_key[i] == k)
				return i;
		return -1;
	endfunction

	function automatic logic [CAP_W-1:0] eff_capacity();
		if (cap_reg == '0)
			return 5'd1;
		if (cap_reg > LKT_ENTRIES)
			return LKT_ENTRIES[CAP_W-1:0];
		return cap_reg;
	endfunction

	// Apply one request to the shadow list and return the result it owes.
	function automatic lru_result_t lru_apply(logic [REQ_W-1:0] rq, logic [PORT_KEY_W-1:0] k);
		lru_result_t res;
		int          slot;
		logic [3:0]  rk;
		res  = '0;
		slot = -1;
		case (rq)
			REQ_TOUCH: begin
				slot = shadow_find(k);
				if (slot >= 0) begin
					// hit: everything newer than it ages by one
					rk      = shadow_rank[slot];
					res.hit = 1'b1;
					for (int i = 0; i < LKT_ENTRIES; i++)
						if (shadow_valid[i] && shadow_rank[i] < rk)
							shadow_rank[i]++;
					shadow_rank[slot] = '0;
				end else if (held_count >= eff_capacity()) begin
					res.status = STAT_FULL;
				end else begin
					// lowest free slot takes the new key
					for (int i = LKT_ENTRIES - 1; i >= 0; i--)
						if (!shadow_valid[i])
							slot = i;
					if (slot < 0) begin
						res.status = STAT_FULL;
					end else begin
						for (int i = 0; i < LKT_ENTRIES; i++)
							if (shadow_valid[i])
								shadow_rank[i]++;
						shadow_valid[slot] = 1'b1;
						shadow_key[slot]   = k;
						shadow_rank[slot]  = '0;
						held_count++;
					end
				end
			end
			REQ_EVICT: begin
				if (held_count == '0) begin
					res.status = STAT_EMPTY;
				end else begin
					for (int i = 0; i < LKT_ENTRIES; i++)
						if (slot < 0 && shadow_valid[i] && shadow_rank[i] == held_count - 1)
							slot = i;
					if (slot >= 0) begin
						res.evicted        = shadow_key[slot];
						shadow_valid[slot] = 1'b0;
						shadow_rank[slot]  = '0;
						held_count--;
					end
				end
			end
			REQ_DELETE: begin
				slot = shadow_find(k);
				if (slot < 0) begin
					res.status = STAT_ABSENT;
				end else begin
					rk                 = shadow_rank[slot];
					shadow_valid[slot] = 1'b0;
					shadow_rank[slot]  = '0;
					for (int i = 0; i < LKT_ENTRIES; i++)
						if (shadow_valid[i] && shadow_rank[i] > rk)
							shadow_rank[i]--;
					held_count--;
				end
			end
			default: ;
		endcase
		res.occupancy = held_count;
		return res;
	endfunction

	// ---------------------------------------------------------------
	// Request side. Called at a rising edge; returns at the edge that
	// accepted the transfer. start stays high so back-to-back requests
	// never drop it within one step.
	// ---------------------------------------------------------------
	task automatic issue_req(input logic [REQ_W-1:0] rq, input logic [PORT_KEY_W-1:0] k,
		input logic use_typed, input lru_result_t typed);
		lru_result_t res;
		start    <= 1'b1;
		req_type <= rq;
		key      <= k;
		do @(posedge clk); while (busy);
		res = lru_apply(rq, k);
		pending_results.push_back(use_typed ? typed : res);
		n_reqs++;
		n_hits   += res.hit;
		n_full   += (res.status == STAT_FULL);
		n_absent += (res.status == STAT_ABSENT);
		n_empty  += (res.status == STAT_EMPTY);
		n_evicts += (rq == REQ_EVICT && res.status == STAT_OK);
	endtask

	// random sender gap after a transfer
	task automatic sender_gap();
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// capacity is only written with nothing in flight
	task automatic write_capacity(input logic [CAP_W-1:0] v);
		start <= 1'b0;
		while (pending_results.size() != 0 || busy)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cap_reg = v;
		cfg_we <= 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Result side: done is a one-cycle strobe, compare against the
	// oldest owed result.
	// ---------------------------------------------------------------
	task automatic check_field(input string name, input logic [63:0] exp_v,
		input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result transfer with none outstanding: status %0d occ %0d",
					$time, status, occupancy);
			end else begin
				mon_exp = pending_results.pop_front();
				check_field("status", 64'(mon_exp.status), 64'(status));
				check_field("hit", 64'(mon_exp.hit), 64'(hit));
				check_field("evicted_key", mon_exp.evicted, evicted_key);
				check_field("occupancy", 64'(mon_exp.occupancy), 64'(occupancy));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still owed", $time, pending_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin
		logic [PORT_KEY_W-1:0] key_pool [24];
		int                    pool_n;
		int                    done_reqs;
		int                    pick;
		lru_result_t           typed;

		for (int i = 0; i < LKT_ENTRIES; i++) begin
			shadow_key[i]   = '0;
			shadow_valid[i] = 1'b0;
			shadow_rank[i]  = '0;
		end
		held_count = '0;
		cap_reg    = CAP_RESET;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, back to back
		idle_pct = 0;
		for (int r = 0; r < N_ROWS; r++) begin
			if (dir_rows[r].kind == ROW_CFG) begin
				write_capacity(dir_rows[r].k[CAP_W-1:0]);
			end else begin
				typed = '{dir_rows[r].st, dir_rows[r].ht, dir_rows[r].ev, dir_rows[r].occ};
				issue_req(dir_rows[r].rq, dir_rows[r].k, dir_rows[r].chk, typed);
			end
		end

		// random phases
		for (int p = 0; p < N_PHASES; p++) begin
			write_capacity(PH_CAP[p]);
			idle_pct = PH_IDLE[p];
			// pool a little larger than the capacity so hits, misses and
			// full-table refusals all show up
			pool_n = eff_capacity() + 3;
			for (int i = 0; i < pool_n; i++)
				key_pool[i] = {$urandom, $urandom};
			done_reqs = 0;
			while (done_reqs < PH_REQS[p]) begin
				pick = $urandom_range(99);
				if (pick < 50) begin
					issue_req(REQ_TOUCH, key_pool[$urandom_range(pool_n - 1)], 1'b0, '0);
				end else if (pick < 55) begin
					issue_req(REQ_TOUCH, {$urandom, $urandom}, 1'b0, '0);
				end else if (pick < 72) begin
					issue_req(REQ_EVICT, {$urandom, $urandom}, 1'b0, '0);
				end else if (pick < 88) begin
					issue_req(REQ_DELETE, key_pool[$urandom_range(pool_n - 1)], 1'b0, '0);
				end else if (pick < 93) begin
					issue_req(REQ_DELETE, {$urandom, $urandom}, 1'b0, '0);
				end else begin
					// ignored type, not counted toward the phase
					issue_req(REQ_UNUSED, key_pool[$urandom_range(pool_n - 1)], 1'b0, '0);
					done_reqs--;
				end
				done_reqs++;
				sender_gap();
			end
		end

		// drain
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d requests over %0d capacity settings: %0d hits, %0d evictions,",
			n_reqs, N_PHASES + 4, n_hits, n_evicts);
		$display("  %0d full-table refusals, %0d absent deletes, %0d evicts on empty, %0d errors",
			n_full, n_absent, n_empty, errors);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
